/* hdl/bft_pkg.sv */
`timescale 1ns / 1ps

package bft_pkg;

  // Store geometry.
  localparam int MAX_WIDTH     = 64;
  localparam int MAX_HEIGHT    = 64;
  localparam int CHANNELS      = 32;
  localparam int FRACTION_BITS = 16;

  localparam int X_W        = $clog2(MAX_WIDTH);
  localparam int Y_W        = $clog2(MAX_HEIGHT);
  localparam int CH_W       = $clog2(CHANNELS);
  localparam int STORE_AW   = X_W + Y_W + CH_W;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT * CHANNELS;
  localparam int ENTRY_W    = 13;

  // Field widths.
  localparam int OFS_W  = 8;
  localparam int DIM_W  = 7;
  localparam int THR_W  = 30;
  localparam int MEAN_W = 29;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 30;

  // Datapath widths.
  localparam int COORD_W = 9;
  localparam int SUM_W   = 15;
  localparam int AREA_W  = 13;
  localparam int PROD_W  = THR_W + AREA_W + 1;
  localparam int REM_W   = AREA_W + 1;
  localparam int DVD_W   = 32;
  localparam int DIV_STEP   = 4;
  localparam int DIV_STAGES = DVD_W / DIV_STEP;

  localparam logic [MEAN_W-1:0] MEAN_MAX = '1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RECT_LEFT    = 3'd0,
    REG_RECT_TOP     = 3'd1,
    REG_RECT_RIGHT   = 3'd2,
    REG_RECT_BOTTOM  = 3'd3,
    REG_CHANNEL      = 3'd4,
    REG_THRESHOLD    = 3'd5,
    REG_IMAGE_WIDTH  = 3'd6,
    REG_IMAGE_HEIGHT = 3'd7
  } cfg_reg_t;

  // Input item actions.
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Corner read order of a query.
  localparam logic [1:0] CORNER_BR   = 2'd0;
  localparam logic [1:0] CORNER_BL   = 2'd1;
  localparam logic [1:0] CORNER_TR   = 2'd2;
  localparam logic [1:0] CORNER_TL   = 2'd3;

endpackage

/* hdl/box_feature_threshold.sv */
`timescale 1ns / 1ps

// Box feature threshold. Load transactions (action 0) write one 13-bit entry of the
// integral image store, can be taken back to back and give no result. Query transactions
// (action 1) read the store once per rectangle corner, one corner after another, because
// the integral store has a single port and each corner is one read. A load that follows
// a query waits until the query's last corner has been read and the sequencer is idle,
// whereas a further query may already be taken during that last corner read. A query's
// result passes through the four reads, sum, multiply, the divider input register, an
// eight-stage divider and the output register. Every stage moves only when the output
// register is free or being emptied, so back-pressure on the result channel stalls the
// whole pipeline without loss. mean_q16 is the box sum over the clipped area in unsigned
// Q16, truncated and saturated; decision is exact. The store has no reset; every entry
// must be loaded before a query reads it.
module box_feature_threshold (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_action,
  input  logic [5:0]                      in_pixel_x,
  input  logic [5:0]                      in_pixel_y,
  input  logic [4:0]                      in_load_channel,
  input  logic [12:0]                     in_load_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [bft_pkg::MEAN_W-1:0]      out_mean_q16,
  output logic                            out_decision,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bft_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bft_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bft_pkg::*;

  // Configuration registers.
  logic [OFS_W-1:0] left_r, top_r, right_r, bottom_r;
  logic [CH_W-1:0]  chan_r;
  logic [THR_W-1:0] thr_r;
  logic [DIM_W-1:0] img_w_r, img_h_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      top_r    <= '0;
      right_r  <= OFS_W'(1);
      bottom_r <= OFS_W'(1);
      chan_r   <= '0;
      thr_r    <= '0;
      img_w_r  <= DIM_W'(MAX_WIDTH);
      img_h_r  <= DIM_W'(MAX_HEIGHT);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_RECT_LEFT:    left_r   <= cfg_data[OFS_W-1:0];
        REG_RECT_TOP:     top_r    <= cfg_data[OFS_W-1:0];
        REG_RECT_RIGHT:   right_r  <= cfg_data[OFS_W-1:0];
        REG_RECT_BOTTOM:  bottom_r <= cfg_data[OFS_W-1:0];
        REG_CHANNEL:      chan_r   <= cfg_data[CH_W-1:0];
        REG_THRESHOLD:    thr_r    <= cfg_data[THR_W-1:0];
        REG_IMAGE_WIDTH:  img_w_r  <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: img_h_r  <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Global pipeline advance: the output register is free or being taken.
  logic out_valid_r;
  logic en;
  assign en = !out_valid_r || out_ready;

  // Corner sequencer state.
  logic       busy_r;
  logic [1:0] cnt_r;
  logic       accept;

  // During the last corner read only a query may enter, as a load would need the port.
  assign in_ready = rst_n && en &&
                    (!busy_r || (cnt_r == CORNER_TL && in_action == ACT_QUERY));
  assign accept   = in_valid && in_ready;

  // Clip the shifted rectangle to the image in use.
  logic [DIM_W-1:0]          wc, hc;
  logic signed [COORD_W-1:0] x1, y1, x2, y2, w9, h9, cx1, cy1, cx2, cy2;
  logic                      q_empty;

  always_comb begin
    if (img_w_r == '0)                     wc = DIM_W'(1);
    else if (img_w_r > DIM_W'(MAX_WIDTH))  wc = DIM_W'(MAX_WIDTH);
    else                                   wc = img_w_r;
    if (img_h_r == '0)                     hc = DIM_W'(1);
    else if (img_h_r > DIM_W'(MAX_HEIGHT)) hc = DIM_W'(MAX_HEIGHT);
    else                                   hc = img_h_r;
    w9 = signed'({2'b00, wc});
    h9 = signed'({2'b00, hc});
    x1 = signed'({3'b000, in_pixel_x}) + signed'({left_r[OFS_W-1], left_r});
    y1 = signed'({3'b000, in_pixel_y}) + signed'({top_r[OFS_W-1], top_r});
    x2 = signed'({3'b000, in_pixel_x}) + signed'({right_r[OFS_W-1], right_r});
    y2 = signed'({3'b000, in_pixel_y}) + signed'({bottom_r[OFS_W-1], bottom_r});
    cx1 = (x1 < 0) ? '0 : x1;
    cy1 = (y1 < 0) ? '0 : y1;
    cx2 = (x2 > w9) ? w9 : x2;
    cy2 = (y2 > h9) ? h9 : y2;
    q_empty = (x1 >= w9) || (x2 <= 0) || (y1 >= h9) || (y2 <= 0) ||
              !(cx1 < cx2) || !(cy1 < cy2);
  end

  // Registered query geometry.
  logic [X_W-1:0]  qx1_r;
  logic [Y_W-1:0]  qy1_r;
  logic [DIM_W-1:0] qx2_r, qy2_r;
  logic            qempty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (en) begin
      if (accept && in_action == ACT_QUERY) begin
        busy_r <= 1'b1;
        cnt_r  <= CORNER_BR;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == CORNER_TL) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && accept && in_action == ACT_QUERY) begin
      qx1_r    <= cx1[X_W-1:0];
      qy1_r    <= cy1[Y_W-1:0];
      qx2_r    <= cx2[DIM_W-1:0];
      qy2_r    <= cy2[DIM_W-1:0];
      qempty_r <= q_empty;
    end
  end

  // Corner address and sign for the current read.
  logic [X_W-1:0]   xa, xb;
  logic [Y_W-1:0]   ya, yb;
  logic [X_W-1:0]   rx;
  logic [Y_W-1:0]   ry;
  logic             r_use, r_neg;
  logic [DIM_W-1:0] dx, dy;
  logic [AREA_W-1:0] area_c;

  always_comb begin
    xa = X_W'(qx2_r - DIM_W'(1));
    ya = Y_W'(qy2_r - DIM_W'(1));
    xb = qx1_r - X_W'(1);
    yb = qy1_r - Y_W'(1);
    unique case (cnt_r)
      CORNER_BR: begin rx = xa; ry = ya; r_use = 1'b1;               r_neg = 1'b0; end
      CORNER_BL: begin rx = xb; ry = ya; r_use = (qx1_r != '0);      r_neg = 1'b1; end
      CORNER_TR: begin rx = xa; ry = yb; r_use = (qy1_r != '0);      r_neg = 1'b1; end
      default:   begin
        rx = xb; ry = yb; r_use = (qx1_r != '0) && (qy1_r != '0); r_neg = 1'b0;
      end
    endcase
    r_use  = r_use && !qempty_r;
    dx     = qx2_r - DIM_W'(qx1_r);
    dy     = qy2_r - DIM_W'(qy1_r);
    area_c = AREA_W'(dx * dy);
  end

  // Integral store: one write or one read per cycle while the pipeline advances, read data registered.
  logic [ENTRY_W-1:0] store_mem [0:STORE_DEPTH-1];
  logic [ENTRY_W-1:0] rd_data_r;
  logic               rd_valid_r, rd_use_r, rd_neg_r, rd_first_r, rd_last_r, rd_empty_r;
  logic [AREA_W-1:0]  rd_area_r;

  always_ff @(posedge clk) begin
    if (accept && in_action == ACT_LOAD) begin
      store_mem[{in_pixel_y, in_pixel_x, in_load_channel}] <= in_load_value;
    end else if (en) begin
      rd_data_r <= store_mem[{ry, rx, chan_r}];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else if (en) begin
      rd_valid_r <= busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_use_r   <= r_use;
      rd_neg_r   <= r_neg;
      rd_first_r <= (cnt_r == CORNER_BR);
      rd_last_r  <= (cnt_r == CORNER_TL);
      rd_area_r  <= qempty_r ? '0 : area_c;
      rd_empty_r <= qempty_r;
    end
  end

  // Accumulate the four corners into the box sum.
  logic signed [SUM_W-1:0] acc_r, term, acc_nxt;
  logic                    s1_valid_r, s1_empty_r;
  logic signed [SUM_W-1:0] s1_sum_r;
  logic [AREA_W-1:0]       s1_area_r;

  always_comb begin
    term    = rd_use_r ? signed'(SUM_W'(rd_data_r)) : '0;
    if (rd_neg_r) term = -term;
    acc_nxt = (rd_first_r ? '0 : acc_r) + term;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= rd_valid_r && rd_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en && rd_valid_r) begin
      acc_r <= acc_nxt;
      if (rd_last_r) begin
        s1_sum_r   <= acc_nxt;
        s1_area_r  <= rd_area_r;
        s1_empty_r <= rd_empty_r;
      end
    end
  end

  // Threshold product and divider operands.
  logic                    s2_valid_r, s2_empty_r, s2_thr_neg_r;
  logic signed [PROD_W-1:0] s2_prod_r;
  logic signed [SUM_W-1:0]  s2_sum_r;
  logic [DVD_W-1:0]        s2_dvd_r;
  logic [AREA_W-1:0]       s2_dsr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_prod_r    <= PROD_W'(signed'(thr_r) * signed'({1'b0, s1_area_r}));
      s2_sum_r     <= s1_sum_r;
      s2_empty_r   <= s1_empty_r;
      s2_thr_neg_r <= thr_r[THR_W-1];
      s2_dvd_r     <= (!s1_empty_r && s1_sum_r > 0) ?
                      DVD_W'({s1_sum_r[SUM_W-2:0], {FRACTION_BITS{1'b0}}}) : '0;
      s2_dsr_r     <= s1_empty_r ? AREA_W'(1) : s1_area_r;
    end
  end

  // Decision: sum scaled to Q16 against threshold times area.
  logic signed [PROD_W-1:0] lhs;
  logic                     dec_c;

  always_comb begin
    lhs   = PROD_W'(signed'({s2_sum_r, {FRACTION_BITS{1'b0}}}));
    dec_c = s2_empty_r ? s2_thr_neg_r : (lhs > s2_prod_r);
  end

  // Pipelined restoring divider, DIV_STEP quotient bits per stage.
  logic              dv_valid_r [0:DIV_STAGES];
  logic              dv_dec_r   [0:DIV_STAGES];
  logic [REM_W-1:0]  dv_rem_r   [0:DIV_STAGES];
  logic [DVD_W-1:0]  dv_dvd_r   [0:DIV_STAGES];
  logic [DVD_W-1:0]  dv_quo_r   [0:DIV_STAGES];
  logic [AREA_W-1:0] dv_dsr_r   [0:DIV_STAGES];
  logic [REM_W-1:0]  dv_rem_nxt [0:DIV_STAGES-1];
  logic [DVD_W-1:0]  dv_dvd_nxt [0:DIV_STAGES-1];
  logic [DVD_W-1:0]  dv_quo_nxt [0:DIV_STAGES-1];

  for (genvar gs = 0; gs < DIV_STAGES; gs++) begin : g_div
    always_comb begin
      logic [REM_W-1:0] rem;
      logic [DVD_W-1:0] dvd, quo;
      rem = dv_rem_r[gs];
      dvd = dv_dvd_r[gs];
      quo = dv_quo_r[gs];
      for (int k = 0; k < DIV_STEP; k++) begin
        rem = {rem[REM_W-2:0], dvd[DVD_W-1]};
        dvd = {dvd[DVD_W-2:0], 1'b0};
        if (rem >= REM_W'(dv_dsr_r[gs])) begin
          rem = rem - REM_W'(dv_dsr_r[gs]);
          quo = {quo[DVD_W-2:0], 1'b1};
        end else begin
          quo = {quo[DVD_W-2:0], 1'b0};
        end
      end
      dv_rem_nxt[gs] = rem;
      dv_dvd_nxt[gs] = dvd;
      dv_quo_nxt[gs] = quo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= DIV_STAGES; s++) dv_valid_r[s] <= 1'b0;
    end else if (en) begin
      dv_valid_r[0] <= s2_valid_r;
      for (int s = 0; s < DIV_STAGES; s++) dv_valid_r[s+1] <= dv_valid_r[s];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem_r[0] <= '0;
      dv_dvd_r[0] <= s2_dvd_r;
      dv_quo_r[0] <= '0;
      dv_dsr_r[0] <= s2_dsr_r;
      dv_dec_r[0] <= dec_c;
      for (int s = 0; s < DIV_STAGES; s++) begin
        dv_rem_r[s+1] <= dv_rem_nxt[s];
        dv_dvd_r[s+1] <= dv_dvd_nxt[s];
        dv_quo_r[s+1] <= dv_quo_nxt[s];
        dv_dsr_r[s+1] <= dv_dsr_r[s];
        dv_dec_r[s+1] <= dv_dec_r[s];
      end
    end
  end

  // Output register with saturation of the mean.
  logic [MEAN_W-1:0] out_mean_r;
  logic              out_dec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_valid_r[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_mean_r <= (dv_quo_r[DIV_STAGES] > DVD_W'(MEAN_MAX)) ?
                    MEAN_MAX : dv_quo_r[DIV_STAGES][MEAN_W-1:0];
      out_dec_r  <= dv_dec_r[DIV_STAGES];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_mean_q16 = out_mean_r;
  assign out_decision = out_dec_r;

endmodule

/* hdl/bft_checker.sv */
`timescale 1ns / 1ps

module bft_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           in_action,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [bft_pkg::MEAN_W-1:0]     out_mean_q16,
  input logic                           out_decision
);
  import bft_pkg::*;

  // A held result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction withdrawn before acceptance");

  // A held result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_mean_q16) && $stable(out_decision))
    else $error("result payload changed while stalled");

  // Reset empties the result register.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A query occupies the store port, so no transaction follows it at once.
  a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_action == ACT_QUERY |=> !in_ready)
    else $error("transaction accepted during corner reads");

endmodule

bind box_feature_threshold bft_checker u_bft_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_action    (in_action),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_mean_q16 (out_mean_q16),
  .out_decision (out_decision)
);

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import bft_pkg::*;

  typedef struct packed {
    logic [MEAN_W-1:0] mean_q16;
    logic              decision;
  } box_result_t;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLD_CYCLES    = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_action = ACT_LOAD;
  logic [5:0] in_pixel_x = '0;
  logic [5:0] in_pixel_y = '0;
  logic [4:0] in_load_channel = '0;
  logic [12:0] in_load_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [MEAN_W-1:0] out_mean_q16;
  logic out_decision;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow copy of the registers and of the integral store.
  logic signed [OFS_W-1:0] sh_left = 8'sd0, sh_top = 8'sd0;
  logic signed [OFS_W-1:0] sh_right = 8'sd1, sh_bottom = 8'sd1;
  logic [CH_W-1:0] sh_channel = '0;
  logic [THR_W-1:0] sh_threshold = '0;
  logic [DIM_W-1:0] sh_width = 7'd64, sh_height = 7'd64;
  logic [ENTRY_W-1:0] integral_shadow [STORE_DEPTH];
  bit entry_loaded [STORE_DEPTH];

  box_result_t expected_means[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int sent_count = 0;

  box_feature_threshold dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int entry_addr(int x, int y, int ch);
    return ((y * MAX_WIDTH) + x) * CHANNELS + ch;
  endfunction

  // Shifts the rectangle by the pixel and clips it; returns 1 when anything is left.
  function automatic bit clip_box(input logic [5:0] px, input logic [5:0] py,
                                  output int x1, output int y1,
                                  output int x2, output int y2);
    int w, h;
    w = (sh_width == 0) ? 1 : ((sh_width > MAX_WIDTH) ? MAX_WIDTH : int'(sh_width));
    h = (sh_height == 0) ? 1 : ((sh_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(sh_height));
    x1 = int'(px) + int'(sh_left);
    y1 = int'(py) + int'(sh_top);
    x2 = int'(px) + int'(sh_right);
    y2 = int'(py) + int'(sh_bottom);
    if (x1 >= w || x2 <= 0 || y1 >= h || y2 <= 0) return 1'b0;
    if (x1 < 0) x1 = 0;
    if (y1 < 0) y1 = 0;
    if (x2 > w) x2 = w;
    if (y2 > h) y2 = h;
    return (x1 < x2) && (y1 < y2);
  endfunction

  function automatic longint entry_at(int x, int y);
    return longint'(integral_shadow[entry_addr(x, y, int'(sh_channel))]);
  endfunction

  function automatic box_result_t box_mean(input logic [5:0] px, input logic [5:0] py);
    box_result_t r;
    int x1, y1, x2, y2;
    longint total, area, thr, q;
    total = 0;
    area = 0;
    thr = longint'($signed(sh_threshold));
    if (clip_box(px, py, x1, y1, x2, y2)) begin
      total = entry_at(x2 - 1, y2 - 1);
      if (x1 > 0) total -= entry_at(x1 - 1, y2 - 1);
      if (y1 > 0) total -= entry_at(x2 - 1, y1 - 1);
      if (x1 > 0 && y1 > 0) total += entry_at(x1 - 1, y1 - 1);
      area = longint'((x2 - x1) * (y2 - y1));
    end
    r.mean_q16 = '0;
    if (area > 0 && total > 0) begin
      q = (total <<< FRACTION_BITS) / area;
      r.mean_q16 = (q > longint'(MEAN_MAX)) ? MEAN_MAX : q[MEAN_W-1:0];
    end
    if (area > 0) r.decision = (total * (64'sd1 <<< FRACTION_BITS)) > (thr * area);
    else r.decision = thr < 0;
    return r;
  endfunction

  // Offers one transaction; called and left at a rising edge, valid stays high.
  task automatic send_item(input logic act, input logic [5:0] px, input logic [5:0] py,
                           input logic [4:0] ch, input logic [12:0] val);
    int gap;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_pixel_x <= px;
    in_pixel_y <= py;
    in_load_channel <= ch;
    in_load_value <= val;
    do @(posedge clk); while (!in_ready);
    sent_count++;
    if (act == ACT_LOAD) begin
      integral_shadow[entry_addr(px, py, ch)] = val;
      entry_loaded[entry_addr(px, py, ch)] = 1'b1;
    end else begin
      expected_means.push_back(box_mean(px, py));
    end
  endtask

  task automatic load_if_missing(int x, int y);
    if (!entry_loaded[entry_addr(x, y, int'(sh_channel))])
      send_item(ACT_LOAD, x[5:0], y[5:0], sh_channel, 13'($urandom));
  endtask

  // A query preceded by loads of any corner it would read that holds nothing yet.
  task automatic box_query(input logic [5:0] px, input logic [5:0] py);
    int x1, y1, x2, y2;
    if (clip_box(px, py, x1, y1, x2, y2)) begin
      load_if_missing(x2 - 1, y2 - 1);
      if (x1 > 0) load_if_missing(x1 - 1, y2 - 1);
      if (y1 > 0) load_if_missing(x2 - 1, y1 - 1);
      if (x1 > 0 && y1 > 0) load_if_missing(x1 - 1, y1 - 1);
    end
    send_item(ACT_QUERY, px, py, 5'($urandom), 13'($urandom));
  endtask

  // Drains the block so that the registers may be written.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_config(input int l, input int t, input int r, input int b,
                              input int ch, input int thr, input int w, input int h);
    logic [CFG_DATA_W-1:0] vals [8];
    cfg_reg_t idx;
    vals = '{30'(l), 30'(t), 30'(r), 30'(b), 30'(ch), 30'(thr), 30'(w), 30'(h)};
    for (int i = 0; i < 8; i++) begin
      idx = cfg_reg_t'(i);
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      case (idx)
        REG_RECT_LEFT:    sh_left = vals[i][OFS_W-1:0];
        REG_RECT_TOP:     sh_top = vals[i][OFS_W-1:0];
        REG_RECT_RIGHT:   sh_right = vals[i][OFS_W-1:0];
        REG_RECT_BOTTOM:  sh_bottom = vals[i][OFS_W-1:0];
        REG_CHANNEL:      sh_channel = vals[i][CH_W-1:0];
        REG_THRESHOLD:    sh_threshold = vals[i][THR_W-1:0];
        REG_IMAGE_WIDTH:  sh_width = vals[i][DIM_W-1:0];
        REG_IMAGE_HEIGHT: sh_height = vals[i][DIM_W-1:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic random_config();
    int l, t, r, b, thr, w, h;
    if ($urandom_range(3) == 0) begin
      l = $urandom_range(128) - 64;
      t = $urandom_range(128) - 64;
      r = $urandom_range(128) - 64;
      b = $urandom_range(128) - 64;
    end else begin
      l = $urandom_range(16) - 8;
      t = $urandom_range(16) - 8;
      r = l + $urandom_range(1, 8);
      b = t + $urandom_range(1, 8);
    end
    case ($urandom_range(3))
      0: thr = int'($urandom);
      1: thr = $urandom_range(1 << 29) - (1 << 28);
      default: thr = $urandom_range(600000000) - 100000000;
    endcase
    w = ($urandom_range(7) == 0) ? $urandom_range(127) : $urandom_range(1, 64);
    h = ($urandom_range(7) == 0) ? $urandom_range(127) : $urandom_range(1, 64);
    apply_config(l, t, r, b, $urandom_range(31), thr, w, h);
  endtask

  // Reset settings, corners of the image and single-entry boxes.
  task automatic test_defaults();
    box_query(6'd0, 6'd0);
    box_query(6'd63, 6'd63);
    box_query(6'd63, 6'd0);
    box_query(6'd0, 6'd63);
    box_query(6'd17, 6'd42);
    settle();
  endtask

  // Clipping, empty boxes, image sizes out of range and threshold extremes.
  task automatic test_box_edges();
    apply_config(-64, -64, 64, 64, 31, -(1 << 29), 64, 64);
    box_query(6'd0, 6'd0);
    box_query(6'd63, 6'd63);
    box_query(6'd31, 6'd32);
    settle();
    apply_config(10, 0, 20, 4, 0, 5, 5, 64);
    box_query(6'd0, 6'd0);
    settle();
    apply_config(10, 0, 20, 4, 0, -1, 5, 64);
    box_query(6'd0, 6'd0);
    settle();
    apply_config(5, 1, 2, 3, 3, (1 << 29) - 1, 0, 0);
    box_query(6'd9, 6'd9);
    box_query(6'd0, 6'd0);
    settle();
    apply_config(0, 0, 1, 1, 2, 0, 127, 127);
    box_query(6'd63, 6'd63);
    settle();
    apply_config(-1, -1, 0, 0, 2, 1 << 28, 64, 64);
    box_query(6'd1, 6'd1);
    box_query(6'd0, 6'd0);
    settle();
    apply_config(63, 63, 64, 64, 7, -(1 << 28), 64, 64);
    box_query(6'd0, 6'd0);
    box_query(6'd1, 6'd0);
    settle();
  endtask

  // Random queries with their loads, and stray loads, over several settings.
  // The budget counts every transaction sent, loads included.
  task automatic test_random(input int send_pct, input int recv_pct, input int items);
    int stop;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int k = 0; k < 4; k++) begin
      random_config();
      stop = sent_count + items / 4;
      while (sent_count < stop) begin
        if ($urandom_range(4) == 0)
          send_item(ACT_LOAD, 6'($urandom), 6'($urandom), 5'($urandom), 13'($urandom));
        else
          box_query(6'($urandom), 6'($urandom));
      end
      settle();
    end
  endtask

  // The receiver stops for a long stretch while queries keep coming.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_config(-2, -2, 3, 3, 1, 200000, 64, 64);
    hold_request = 1'b1;
    for (int i = 0; i < 40; i++) box_query(6'($urandom), 6'($urandom));
    settle();
  endtask

  // Result receiver with random idling and the long hold-off.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compares each result transaction with the oldest expectation.
  always @(posedge clk) begin
    box_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_means.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: mean_q16=%0d decision=%0b", out_mean_q16, out_decision);
      end else begin
        want = expected_means.pop_front();
        if (want.mean_q16 !== out_mean_q16 || want.decision !== out_decision) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected mean_q16=%0d decision=%0b, got %0d %0b",
                     want.mean_q16, want.decision, out_mean_q16, out_decision);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_box_edges();
    test_random(12, 48, 120);
    test_random(48, 12, 120);
    test_random(0, 0, 120);
    test_backpressure();
    if (mismatches == 0 && expected_means.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
